[rtl/core/dsd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the door signed distance pipeline.
package dsd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int SQRT_STAGES = 32;
    localparam int CW          = 34;   // coordinate width at doubled scale
    localparam int CFG_DW      = 48;

    localparam logic [23:0] RST_DOOR_POS  = 24'd0;
    localparam logic [31:0] RST_ROTATION  = 32'h4000_0000;
    localparam logic [22:0] RST_WIDTH     = 23'd58982;
    localparam logic [22:0] RST_HEIGHT    = 23'd131072;
    localparam logic [47:0] RST_THICKNESS = 48'd28148010076717;

    typedef enum logic [2:0] {
        REG_DOOR_X          = 3'd0,
        REG_DOOR_Y          = 3'd1,
        REG_DOOR_Z          = 3'd2,
        REG_DOOR_ROTATION   = 3'd3,
        REG_LEAF_ROTATION   = 3'd4,
        REG_OPENING_WIDTH   = 3'd5,
        REG_OPENING_HEIGHT  = 3'd6,
        REG_PART_THICKNESS  = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic signed [23:0] door_x;
        logic signed [23:0] door_y;
        logic signed [23:0] door_z;
        logic [31:0]        door_rotation;
        logic [31:0]        leaf_rotation;
        logic [22:0]        opening_width;
        logic [22:0]        opening_height;
        logic [47:0]        part_thickness;
    } t_cfg;

    // Point in door frame and in leaf frame, doubled scale.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] lx;
        logic signed [CW-1:0] ly;
    } t_frame_pt;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[rtl/core/dsd_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module dsd_sqrt
    import dsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    logic [33:0] s_rem  [0:SQRT_STAGES];
    logic [31:0] s_root [0:SQRT_STAGES];
    logic [63:0] s_rad  [0:SQRT_STAGES];

    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_rad[0]  = i_rad;

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [35:0] w_cur;
        logic [35:0] w_trial;
        logic [35:0] w_diff;
        logic [33:0] r_rem;
        logic [31:0] r_root;
        logic [63:0] r_rad;

        // bring down the next two radicand bits
        assign w_cur   = {s_rem[k], s_rad[k][63:62]};
        assign w_trial = {2'b00, s_root[k], 2'b01};
        assign w_diff  = w_cur - w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cur >= w_trial) begin
                    r_rem  <= w_diff[33:0];
                    r_root <= {s_root[k][30:0], 1'b1};
                end else begin
                    r_rem  <= w_cur[33:0];
                    r_root <= {s_root[k][30:0], 1'b0};
                end
                r_rad <= {s_rad[k][61:0], 2'b00};
            end
        end

        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
        assign s_rad[k+1]  = r_rad;
    end

    assign o_root = s_root[SQRT_STAGES];

endmodule

[rtl/core/dsd_front.sv]
`timescale 1ns / 1ps
// Front pipeline: translate and rotate the point into door and leaf frames.
module dsd_front
    import dsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [23:0] i_point_x,
    input  logic signed [23:0] i_point_y,
    input  logic signed [23:0] i_point_z,
    input  t_q_stat            i_qstat,
    output logic               o_push,
    output t_frame_pt          o_entry
);

    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    logic signed [15:0] w_dc, w_ds, w_lc, w_ls;
    logic signed [24:0] w_tx, w_ty, w_tz;
    logic signed [24:0] r_tx, r_ty, r_tz;
    logic signed [40:0] r_m_ctx, r_m_sty, r_m_stx, r_m_cty;
    logic signed [24:0] r_tz2;
    logic signed [41:0] w_xacc, w_yacc, w_xr, w_yr;
    logic signed [29:0] w_x, w_y;
    logic signed [30:0] w_p1x;
    logic signed [29:0] r_x3, r_y3;
    logic signed [25:0] r_z3;
    logic signed [30:0] r_p1x3;
    logic signed [46:0] r_m_lcp, r_m_lsp;
    logic signed [45:0] r_m_lsy, r_m_lcy;
    logic signed [29:0] r_x4, r_y4;
    logic signed [25:0] r_z4;
    logic signed [47:0] w_lacc, w_lyacc, w_lr, w_lyr;
    logic signed [CW-1:0] w_wd;
    t_frame_pt r_e5;

    assign w_en    = !i_qstat.full;
    assign o_ready = w_en;
    assign o_push  = w_en && r_v5;
    assign o_entry = r_e5;

    assign w_dc = $signed(i_cfg.door_rotation[31:16]);
    assign w_ds = $signed(i_cfg.door_rotation[15:0]);
    assign w_lc = $signed(i_cfg.leaf_rotation[31:16]);
    assign w_ls = $signed(i_cfg.leaf_rotation[15:0]);
    assign w_wd = $signed({11'b0, i_cfg.opening_width});

    assign w_tx = $signed({i_point_x[23], i_point_x}) - $signed({i_cfg.door_x[23], i_cfg.door_x});
    assign w_ty = $signed({i_point_y[23], i_point_y}) - $signed({i_cfg.door_y[23], i_cfg.door_y});
    assign w_tz = $signed({i_point_z[23], i_point_z}) - $signed({i_cfg.door_z[23], i_cfg.door_z});

    // door frame rotation, round half up from Q.14
    assign w_xacc = r_m_ctx - r_m_sty;
    assign w_yacc = r_m_stx + r_m_cty;
    assign w_xr   = (w_xacc + 42'sd8192) >>> 14;
    assign w_yr   = (w_yacc + 42'sd8192) >>> 14;
    assign w_x    = $signed({w_xr[28:0], 1'b0});
    assign w_y    = $signed({w_yr[28:0], 1'b0});
    assign w_p1x  = 31'(w_x) + $signed({8'b0, i_cfg.opening_width});

    // leaf frame rotation about the hinge
    assign w_lacc  = r_m_lcp + r_m_lsy;
    assign w_lyacc = r_m_lcy - r_m_lsp;
    assign w_lr    = (w_lacc + 48'sd8192) >>> 14;
    assign w_lyr   = (w_lyacc + 48'sd8192) >>> 14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tx <= w_tx;
            r_ty <= w_ty;
            r_tz <= w_tz;

            r_m_ctx <= w_dc * r_tx;
            r_m_sty <= w_ds * r_ty;
            r_m_stx <= w_ds * r_tx;
            r_m_cty <= w_dc * r_ty;
            r_tz2   <= r_tz;

            r_x3   <= w_x;
            r_y3   <= w_y;
            r_z3   <= {r_tz2, 1'b0};
            r_p1x3 <= w_p1x;

            r_m_lcp <= w_lc * r_p1x3;
            r_m_lsp <= w_ls * r_p1x3;
            r_m_lsy <= w_ls * r_y3;
            r_m_lcy <= w_lc * r_y3;
            r_x4    <= r_x3;
            r_y4    <= r_y3;
            r_z4    <= r_z3;

            r_e5.x  <= CW'(r_x4);
            r_e5.y  <= CW'(r_y4);
            r_e5.z  <= CW'(r_z4);
            r_e5.lx <= w_lr[CW-1:0] - w_wd;
            r_e5.ly <= w_lyr[CW-1:0];
        end
    end

endmodule

[rtl/core/dsd_queue.sv]
`timescale 1ns / 1ps
// Small FIFO between the front and back pipelines.
module dsd_queue
    import dsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_frame_pt i_data,
    input  logic      i_pop,
    output t_frame_pt o_data,
    output t_q_stat   o_stat
);

    t_frame_pt           r_mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/core/dsd_back.sv]
`timescale 1ns / 1ps
// Back pipeline: four box distances, square roots, minimum, round and saturate.
module dsd_back
    import dsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_q_stat            i_qstat,
    input  t_frame_pt          i_entry,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_distance
);

    logic w_en;
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic r_vl [0:SQRT_STAGES-1];

    logic signed [CW-1:0] w_w, w_h, w_ft, w_fd, w_lt, w_c_lz, w_c_jx;
    logic signed [CW-1:0] w_lz, w_zh;
    logic [CW-1:0]        w_b   [0:11];
    logic [CW-1:0]        w_abs [0:11];
    logic signed [CW-1:0] r_p   [0:11];
    logic signed [CW:0]   r_q   [0:11];
    logic [31:0]          w_qp  [0:11];
    logic [63:0]          r_sq  [0:11];
    logic signed [CW:0]   w_mx  [0:3];
    logic signed [CW:0]   r_mx2 [0:3];
    logic signed [CW:0]   r_mx3 [0:3];
    logic [63:0]          r_sum [0:3];
    logic [31:0]          w_root [0:3];
    logic signed [CW:0]   r_mxl [0:SQRT_STAGES-1][0:3];
    logic signed [CW:0]   r_d4  [0:3];
    logic signed [CW:0]   r_m5a, r_m5b;
    logic signed [CW:0]   w_dmin, w_r;
    logic signed [23:0]   r_out;

    // advance whenever the output register is free or being taken
    assign w_en       = !r_v6 || i_ready;
    assign o_pop      = w_en && !i_qstat.empty;
    assign o_valid    = r_v6;
    assign o_distance = r_out;

    assign w_w    = $signed({11'b0, i_cfg.opening_width});
    assign w_h    = $signed({11'b0, i_cfg.opening_height});
    assign w_ft   = $signed({18'b0, i_cfg.part_thickness[47:32]});
    assign w_fd   = $signed({18'b0, i_cfg.part_thickness[31:16]});
    assign w_lt   = $signed({18'b0, i_cfg.part_thickness[15:0]});
    assign w_c_lz = $signed({10'b0, i_cfg.opening_height, 1'b0}) + w_ft;
    assign w_c_jx = w_w + w_ft;
    assign w_lz   = i_entry.z - w_c_lz;
    assign w_zh   = i_entry.z - w_h;

    // half extents: lintel, left jamb, right jamb, leaf
    assign w_b[0]  = w_w + w_ft + w_ft;
    assign w_b[1]  = w_fd;
    assign w_b[2]  = w_ft;
    assign w_b[3]  = w_ft;
    assign w_b[4]  = w_fd;
    assign w_b[5]  = w_h;
    assign w_b[6]  = w_ft;
    assign w_b[7]  = w_fd;
    assign w_b[8]  = w_h;
    assign w_b[9]  = w_w;
    assign w_b[10] = w_lt;
    assign w_b[11] = w_h;

    always_comb begin
        for (int i = 0; i < 12; i++) begin
            w_abs[i] = r_p[i][CW-1] ? CW'(-r_p[i]) : r_p[i];
            w_qp[i]  = (r_q[i] > 0) ? r_q[i][31:0] : 32'd0;
        end
        for (int j = 0; j < 4; j++) begin
            w_mx[j] = r_q[3*j];
            if (r_q[3*j+1] > w_mx[j]) begin
                w_mx[j] = r_q[3*j+1];
            end
            if (r_q[3*j+2] > w_mx[j]) begin
                w_mx[j] = r_q[3*j+2];
            end
            if (w_mx[j] > 0) begin
                w_mx[j] = '0;
            end
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_sqrt
        dsd_sqrt u_sqrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (r_sum[j]),
            .o_root (w_root[j])
        );
    end

    assign w_dmin = (r_m5a < r_m5b) ? r_m5a : r_m5b;
    assign w_r    = (w_dmin + 35'sd1) >>> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_vl[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_v0    <= o_pop;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_vl[0] <= r_v3;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                r_vl[k] <= r_vl[k-1];
            end
            r_v4 <= r_vl[SQRT_STAGES-1];
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // shift each point into its box's centered frame
            r_p[0]  <= i_entry.x;
            r_p[1]  <= i_entry.y;
            r_p[2]  <= w_lz;
            r_p[3]  <= i_entry.x + w_c_jx;
            r_p[4]  <= i_entry.y;
            r_p[5]  <= w_zh;
            r_p[6]  <= i_entry.x - w_c_jx;
            r_p[7]  <= i_entry.y;
            r_p[8]  <= w_zh;
            r_p[9]  <= i_entry.lx;
            r_p[10] <= i_entry.ly;
            r_p[11] <= w_zh;

            for (int i = 0; i < 12; i++) begin
                r_q[i]  <= $signed({1'b0, w_abs[i]}) - $signed({1'b0, w_b[i]});
                r_sq[i] <= w_qp[i] * w_qp[i];
            end

            for (int j = 0; j < 4; j++) begin
                r_mx2[j] <= w_mx[j];
                r_mx3[j] <= r_mx2[j];
                r_sum[j] <= r_sq[3*j] + r_sq[3*j+1] + r_sq[3*j+2] + 64'd2;
                r_mxl[0][j] <= r_mx3[j];
                for (int k = 1; k < SQRT_STAGES; k++) begin
                    r_mxl[k][j] <= r_mxl[k-1][j];
                end
                r_d4[j] <= $signed({3'b0, w_root[j]}) + r_mxl[SQRT_STAGES-1][j];
            end

            r_m5a <= (r_d4[0] < r_d4[1]) ? r_d4[0] : r_d4[1];
            r_m5b <= (r_d4[2] < r_d4[3]) ? r_d4[2] : r_d4[3];

            if (w_r > 35'sd8388607) begin
                r_out <= 24'sh7FFFFF;
            end else if (w_r < -35'sd8388608) begin
                r_out <= 24'sh800000;
            end else begin
                r_out <= w_r[23:0];
            end
        end
    end

endmodule

[rtl/core/door_signed_distance_top.sv]
`timescale 1ns / 1ps
// Throughput: one point per cycle while the queue is not full; the output
// register and the 4-entry queue between the transform pipeline and the
// distance pipeline absorb stalls.
// The 32-stage square root pipeline sets most of the latency.
// Reset is synchronous, active low: clears valid state and loads register defaults.
module door_signed_distance_top
    import dsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [71:0]       i_s_axis_tdata,   // point_x, point_y, point_z
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [23:0]       o_m_axis_tdata,   // distance
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cfg               r_cfg;
    t_q_stat            w_qstat;
    t_frame_pt          w_push_data, w_pop_data;
    logic               w_push, w_pop;
    logic signed [23:0] w_distance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.door_x         <= RST_DOOR_POS;
            r_cfg.door_y         <= RST_DOOR_POS;
            r_cfg.door_z         <= RST_DOOR_POS;
            r_cfg.door_rotation  <= RST_ROTATION;
            r_cfg.leaf_rotation  <= RST_ROTATION;
            r_cfg.opening_width  <= RST_WIDTH;
            r_cfg.opening_height <= RST_HEIGHT;
            r_cfg.part_thickness <= RST_THICKNESS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_DOOR_X:         r_cfg.door_x         <= i_cfg_data[23:0];
                REG_DOOR_Y:         r_cfg.door_y         <= i_cfg_data[23:0];
                REG_DOOR_Z:         r_cfg.door_z         <= i_cfg_data[23:0];
                REG_DOOR_ROTATION:  r_cfg.door_rotation  <= i_cfg_data[31:0];
                REG_LEAF_ROTATION:  r_cfg.leaf_rotation  <= i_cfg_data[31:0];
                REG_OPENING_WIDTH:  r_cfg.opening_width  <= i_cfg_data[22:0];
                REG_OPENING_HEIGHT: r_cfg.opening_height <= i_cfg_data[22:0];
                REG_PART_THICKNESS: r_cfg.part_thickness <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    dsd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_point_x (i_s_axis_tdata[23:0]),
        .i_point_y (i_s_axis_tdata[47:24]),
        .i_point_z (i_s_axis_tdata[71:48]),
        .i_qstat   (w_qstat),
        .o_push    (w_push),
        .o_entry   (w_push_data)
    );

    dsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_stat  (w_qstat)
    );

    dsd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_qstat    (w_qstat),
        .i_entry    (w_pop_data),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_distance (w_distance)
    );

    assign o_m_axis_tdata = w_distance;

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_qstat.full))
        else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_qstat.empty))
        else $error("queue pop while empty");
    a_stat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_qstat.full && w_qstat.empty))
        else $error("queue full and empty together");
    a_stall_holds_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("output changed while stalled");
`endif

endmodule
